// File: design/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the cosine similarity engine
// Holds the job descriptor that passes from the accumulator to the solver.
// ----------------------------------------------------------------------------
`default_nettype none
package cse_pkg;
  localparam int unsigned SumW = 48;
  localparam int unsigned RootW = 24;
  localparam int unsigned SimMax = 32767;

  typedef struct packed {
    logic            degen;
    logic            neg;
    logic [SumW-1:0] mag;
    logic [SumW-1:0] sq_a;
    logic [SumW-1:0] sq_b;
  } cse_job_t;
endpackage
`default_nettype wire

// File: design/cosine_similarity_engine_top.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_top: streaming cosine similarity of two vectors
// Accumulates element pairs and emits one similarity per vector.
// ----------------------------------------------------------------------------
// Element pairs are accepted one per clock while full is low: a two-stage
// multiply-accumulate front end takes every transaction. At the element
// marked last, the sums are packed into a job register and then written into
// a four-entry queue. Full rises when the queued jobs plus the jobs still in
// the two front stages reach four, so no job is ever lost; full depends only
// on registers. A back-end sequencer takes each job, then computes the two
// square roots (one root bit per cycle), the multiply, the divide (one
// quotient bit per cycle) and loads the output register; it takes no new job
// until it has finished the last. A vector that is at or below the threshold
// skips the roots and the divide and goes straight to the output register.
// When jobs arrive faster than the back end handles them, they back up and
// full stalls the input. Results wait in an output register until popped; a
// result that is not popped stalls the back end.
`default_nettype none
module cosine_similarity_engine_top import cse_pkg::*; #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_elem_a,
  input  wire logic [15:0] in_elem_b,
  input  wire logic        in_last_element,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_similarity,
  output logic             out_degenerate,
  input  wire logic        cfg_we,
  input  wire logic [29:0] cfg_min_sum_sq
);
  logic [29:0] min_r;
  logic        jv, qne, qrd, rv, acc_pend;
  logic [2:0]  qlvl;
  cse_job_t    jb, qd;

  always_ff @(posedge clk) begin
    if (!rst_n) min_r <= '0;
    else if (cfg_we) min_r <= cfg_min_sum_sq;
  end

  // Reserve a queue entry for every job that is still on its way in.
  assign full = (qlvl + 3'(acc_pend) + 3'(jv)) >= 3'd4;

  cse_accum #(.MAX_LEN(MAX_LEN)) u_acc (
    .clk, .rst_n, .in_valid(push && !full), .elem_a(in_elem_a), .elem_b(in_elem_b),
    .last_element(in_last_element), .min_sum_sq(min_r), .last_pending(acc_pend),
    .job_valid(jv), .job(jb)
  );

  cse_jobq u_q (
    .clk, .rst_n, .wr_en(jv), .wr_data(jb), .not_empty(qne), .level(qlvl),
    .rd_en(qrd), .rd_data(qd)
  );

  cse_solver u_sol (
    .clk, .rst_n, .job_avail(qne), .job(qd), .job_take(qrd),
    .res_valid(rv), .res_sim(out_similarity), .res_degen(out_degenerate),
    .res_take(pop && rv)
  );

  assign empty = !rv;
endmodule
`default_nettype wire

// File: design/cse_accum.sv
// ----------------------------------------------------------------------------
// cse_accum: element-pair accumulator
// Registers the products, then adds them into saturating sums and emits a job
// descriptor on the element marked last.
// ----------------------------------------------------------------------------
`default_nettype none
module cse_accum import cse_pkg::*; #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [15:0]     elem_a,
  input  wire logic [15:0]     elem_b,
  input  wire logic            last_element,
  input  wire logic [29:0]     min_sum_sq,
  output logic                 last_pending,
  output logic                 job_valid,
  output cse_job_t             job
);
  localparam logic [SumW-1:0] Lim = SumW'(MAX_LEN) << 30;

  logic              p_vld_r, p_last_r;
  logic signed [31:0] p_ab_r;
  logic [31:0]       p_aa_r, p_bb_r;
  logic signed [SumW-1:0] dot_r, dot_nxt;
  logic [SumW-1:0]   sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [SumW:0] dsum;
  logic [SumW:0]     asum, bsum;
  logic              job_valid_r;
  cse_job_t          job_r;

  always_ff @(posedge clk) begin
    p_ab_r   <= $signed(elem_a) * $signed(elem_b);
    p_aa_r   <= 32'($signed(elem_a) * $signed(elem_a));
    p_bb_r   <= 32'($signed(elem_b) * $signed(elem_b));
    p_last_r <= last_element;
    if (!rst_n) p_vld_r <= 1'b0;
    else p_vld_r <= in_valid;
  end

  always_comb begin
    dsum = $signed({dot_r[SumW-1], dot_r}) + (SumW+1)'(p_ab_r);
    asum = {1'b0, sa_r} + (SumW+1)'(p_aa_r);
    bsum = {1'b0, sb_r} + (SumW+1)'(p_bb_r);
    if (dsum > $signed({1'b0, Lim})) dot_nxt = Lim;
    else if (dsum < -$signed({1'b0, Lim})) dot_nxt = -Lim;
    else dot_nxt = dsum[SumW-1:0];
    sa_nxt = (asum > {1'b0, Lim}) ? Lim : asum[SumW-1:0];
    sb_nxt = (bsum > {1'b0, Lim}) ? Lim : bsum[SumW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0; sa_r <= '0; sb_r <= '0; job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= p_vld_r && p_last_r;
      if (p_vld_r) begin
        if (p_last_r) begin
          dot_r <= '0; sa_r <= '0; sb_r <= '0;
        end else begin
          dot_r <= dot_nxt; sa_r <= sa_nxt; sb_r <= sb_nxt;
        end
      end
    end
    job_r.degen <= (sa_nxt <= SumW'(min_sum_sq)) || (sb_nxt <= SumW'(min_sum_sq));
    job_r.neg   <= dot_nxt[SumW-1];
    job_r.mag   <= dot_nxt[SumW-1] ? SumW'(-dot_nxt) : dot_nxt;
    job_r.sq_a  <= sa_nxt;
    job_r.sq_b  <= sb_nxt;
  end

  // A last element sits in the product stage and will become a job.
  assign last_pending = p_vld_r && p_last_r;
  assign job_valid = job_valid_r;
  assign job = job_r;
endmodule
`default_nettype wire

// File: design/cse_jobq.sv
// ----------------------------------------------------------------------------
// cse_jobq: small job queue
// Four-entry queue that decouples the accumulator from the solver.
// ----------------------------------------------------------------------------
`default_nettype none
module cse_jobq import cse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  cse_job_t      wr_data,
  output logic          not_empty,
  output logic [2:0]    level,
  input  wire logic     rd_en,
  output cse_job_t      rd_data
);
  cse_job_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end

  assign not_empty = cnt_r != 3'd0;
  assign level = cnt_r;
  assign rd_data = mem_r[rp_r];
endmodule
`default_nettype wire

// File: design/cse_solver.sv
// ----------------------------------------------------------------------------
// cse_solver: root and divide sequencer
// Takes both integer square roots one bit per cycle, multiplies them, then
// divides the scaled dot product one quotient bit per cycle; degenerate jobs skip both.
// ----------------------------------------------------------------------------
`default_nettype none
module cse_solver import cse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_avail,
  input  cse_job_t         job,
  output logic             job_take,
  output logic             res_valid,
  output logic [15:0]      res_sim,
  output logic             res_degen,
  input  wire logic        res_take
);
  localparam logic [2:0] S_IDLE = 3'd0, S_ROOT = 3'd1, S_MUL = 3'd2,
                         S_DIV = 3'd3, S_DONE = 3'd4;
  localparam int unsigned NumW = SumW + 15;

  logic [2:0]        st_r;
  logic [5:0]        cnt_r;
  logic [SumW-1:0]   va_r, vb_r;
  logic [RootW-1:0]  ra_r, rb_r;
  logic [RootW+1:0]  rema_r, remb_r;
  logic [SumW-1:0]   den_r;
  logic [NumW-1:0]   num_r;
  logic [SumW:0]     rem_r;
  logic              neg_r, degen_r, res_valid_r;
  logic [15:0]       sim_r;
  logic [RootW+1:0]  ta, tb, rema_sh, remb_sh;
  logic [SumW:0]     rsh;
  logic [NumW-1:0]   q;

  always_comb begin
    rema_sh = {rema_r[RootW-1:0], va_r[SumW-1 -: 2]};
    remb_sh = {remb_r[RootW-1:0], vb_r[SumW-1 -: 2]};
    ta = {ra_r, 2'b01};
    tb = {rb_r, 2'b01};
    rsh = {rem_r[SumW-1:0], num_r[NumW-1]};
    q = {num_r[NumW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; res_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (job_avail) begin
          degen_r <= job.degen; neg_r <= job.neg;
          num_r <= {job.mag, 15'd0};
          va_r <= job.sq_a; vb_r <= job.sq_b;
          ra_r <= '0; rb_r <= '0; rema_r <= '0; remb_r <= '0;
          cnt_r <= 6'(RootW - 1);
          st_r <= job.degen ? S_DONE : S_ROOT;
        end
        S_ROOT: begin
          va_r <= {va_r[SumW-3:0], 2'b00};
          vb_r <= {vb_r[SumW-3:0], 2'b00};
          if (rema_sh >= ta) begin
            rema_r <= rema_sh - ta; ra_r <= {ra_r[RootW-2:0], 1'b1};
          end else begin
            rema_r <= rema_sh; ra_r <= {ra_r[RootW-2:0], 1'b0};
          end
          if (remb_sh >= tb) begin
            remb_r <= remb_sh - tb; rb_r <= {rb_r[RootW-2:0], 1'b1};
          end else begin
            remb_r <= remb_sh; rb_r <= {rb_r[RootW-2:0], 1'b0};
          end
          if (cnt_r == 6'd0) st_r <= S_MUL;
          else cnt_r <= cnt_r - 6'd1;
        end
        S_MUL: begin
          den_r <= ra_r * rb_r;
          rem_r <= '0;
          cnt_r <= 6'(NumW - 1);
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (rsh >= {1'b0, den_r}) begin
            rem_r <= rsh - {1'b0, den_r}; num_r <= q | NumW'(1);
          end else begin
            rem_r <= rsh; num_r <= q;
          end
          if (cnt_r == 6'd0) st_r <= S_DONE;
          else cnt_r <= cnt_r - 6'd1;
        end
        S_DONE: if (!res_valid_r || res_take) begin
          if (degen_r) sim_r <= '0;
          else if (num_r > NumW'(SimMax)) sim_r <= neg_r ? -16'(SimMax) : 16'(SimMax);
          else sim_r <= neg_r ? -num_r[15:0] : num_r[15:0];
          res_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (res_take && !(st_r == S_DONE)) res_valid_r <= 1'b0;
    end
    if (st_r == S_DONE && (!res_valid_r || res_take)) res_degen <= degen_r;
  end

  assign job_take = st_r == S_IDLE && job_avail;
  assign res_valid = res_valid_r;
  assign res_sim = sim_r;
endmodule
`default_nettype wire

// File: tb/sv/tb_cosine_similarity_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cosine_similarity_engine_top: self-checking bench for the similarity engine
// Streams element pairs, predicts every per-vector similarity and compares it
// with what the engine pops out. Covers threshold settings, sum saturation
// and back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_engine_top;
  import cse_pkg::*;

  localparam int MaxLen = 64;
  // Long enough for the back end to finish a vector, with margin.
  localparam int SettleCycles = 150;
  localparam longint CycleLimit = 200000;
  localparam longint SumLimit = longint'(MaxLen) << 30;

  typedef enum logic [1:0] {ITEM_PAIR, ITEM_CFG, ITEM_PAUSE} item_kind_t;

  typedef struct {
    item_kind_t       kind;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic             last;
    logic [29:0]      thresh;
  } stim_item_t;

  typedef struct {
    logic signed [15:0] sim;
    logic               degen;
  } sim_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [15:0] in_elem_a = '0;
  logic [15:0] in_elem_b = '0;
  logic in_last_element = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] out_similarity;
  logic out_degenerate;
  logic cfg_we = 1'b0;
  logic [29:0] cfg_min_sum_sq = '0;

  always #5 clk = ~clk;

  cosine_similarity_engine_top #(.MAX_LEN(MaxLen)) u_top (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last_element(in_last_element),
    .empty(empty), .pop(pop),
    .out_similarity(out_similarity), .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_min_sum_sq(cfg_min_sum_sq)
  );

  stim_item_t  stim_q[$];
  sim_result_t expected_sims[$];
  stim_item_t  offered;
  longint cycles = 0;
  int mismatches = 0;
  int results_seen = 0;

  // Predictor state: running sums of the current vector pair and the threshold.
  longint dot_acc = 0;
  longint sq_acc_a = 0;
  longint sq_acc_b = 0;
  longint min_sq = 0;

  always @(posedge clk) cycles <= cycles + 1;

  // Both sides stop idling inside this window.
  function automatic logic idle_now();
    if (cycles >= 3000 && cycles < 6000) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  function automatic longint int_root(longint v);
    longint r = 0;
    longint trial;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (longint'(1) << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > SumLimit) return SumLimit;
    if (v < -SumLimit) return -SumLimit;
    return v;
  endfunction

  // Folds one accepted pair into the sums and queues the similarity that
  // the engine owes when the pair closes a vector.
  task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    sim_result_t r;
    longint den;
    longint mag;
    longint q;
    dot_acc = clamp_sum(dot_acc + longint'(a) * longint'(b));
    sq_acc_a = clamp_sum(sq_acc_a + longint'(a) * longint'(a));
    sq_acc_b = clamp_sum(sq_acc_b + longint'(b) * longint'(b));
    if (last) begin
      r.sim = '0;
      r.degen = 1'b0;
      if (sq_acc_a <= min_sq || sq_acc_b <= min_sq) begin
        r.degen = 1'b1;
      end else begin
        den = int_root(sq_acc_a) * int_root(sq_acc_b);
        mag = (dot_acc < 0) ? -dot_acc : dot_acc;
        q = (mag << 15) / den;
        if (q > SimMax) q = SimMax;
        r.sim = (dot_acc < 0) ? 16'(-q) : 16'(q);
      end
      expected_sims.push_back(r);
      dot_acc = 0;
      sq_acc_a = 0;
      sq_acc_b = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Sender: offers queued pairs, performs threshold writes once the engine
  // has drained, and honors pause markers.
  int quiet = 0;
  always @(posedge clk) begin
    logic nxt_push;
    logic nxt_we;
    stim_item_t head;
    nxt_push = push;
    nxt_we = 1'b0;
    if (rst_n) begin
      if (push && !full) begin
        predict_pair(offered.a, offered.b, offered.last);
        nxt_push = 1'b0;
      end
      if (!nxt_push && stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.kind)
          ITEM_CFG: begin
            // Write only after the last result is out and the back end is quiet.
            if (expected_sims.size() == 0) begin
              if (quiet >= SettleCycles) begin
                nxt_we = 1'b1;
                cfg_min_sum_sq <= head.thresh;
                min_sq = longint'(head.thresh);
                void'(stim_q.pop_front());
                quiet <= 0;
              end else begin
                quiet <= quiet + 1;
              end
            end else begin
              quiet <= 0;
            end
          end
          ITEM_PAUSE: begin
            if (expected_sims.size() == 0) void'(stim_q.pop_front());
          end
          default: begin
            if (!idle_now()) begin
              offered = stim_q.pop_front();
              in_elem_a <= offered.a;
              in_elem_b <= offered.b;
              in_last_element <= offered.last;
              nxt_push = 1'b1;
            end
          end
        endcase
      end
    end
    push <= nxt_push;
    cfg_we <= nxt_we;
  end

  // Receiver: pops at random, and once holds off for a long stretch.
  int hold_left = 0;
  logic held = 1'b0;
  always @(posedge clk) begin
    logic nxt_pop;
    sim_result_t want;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_sims.size() == 0) begin
          report_mismatch("unexpected result, similarity", $signed(out_similarity), 0);
        end else begin
          want = expected_sims.pop_front();
          if (out_similarity !== want.sim)
            report_mismatch("similarity", $signed(out_similarity), want.sim);
          if (out_degenerate !== want.degen)
            report_mismatch("degenerate", out_degenerate, want.degen);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!held && results_seen >= 18) begin
        held <= 1'b1;
        hold_left <= 600;
      end else begin
        nxt_pop = !idle_now();
      end
    end
    pop <= nxt_pop;
  end

  task automatic add_pair(int a, int b, logic last);
    stim_item_t it;
    it.kind = ITEM_PAIR;
    it.a = 16'(a);
    it.b = 16'(b);
    it.last = last;
    it.thresh = '0;
    stim_q.push_back(it);
  endtask

  task automatic add_marker(item_kind_t kind, logic [29:0] thresh);
    stim_item_t it;
    it.kind = kind;
    it.a = '0;
    it.b = '0;
    it.last = 1'b0;
    it.thresh = thresh;
    stim_q.push_back(it);
  endtask

  // One random vector pair; the flavor steers the similarity toward
  // aligned, opposed, small or extreme values.
  task automatic add_random_vector(int max_len, int mag);
    int len;
    int flavor;
    int a;
    int b;
    len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, max_len);
    flavor = $urandom_range(0, 4);
    for (int i = 0; i < len; i++) begin
      a = $urandom_range(0, 2 * mag - 1) - mag;
      b = $urandom_range(0, 2 * mag - 1) - mag;
      case (flavor)
        1: b = a;
        2: b = (a == -32768) ? 32767 : -a;
        3: begin
          a = $urandom_range(0, 15) - 8;
          b = $urandom_range(0, 15) - 8;
        end
        4: a = $urandom_range(0, 1) ? 32767 : -32768;
        default: ;
      endcase
      add_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    add_marker(ITEM_CFG, 30'd0);
    // Directed: extremes, zero vectors, opposed and orthogonal pairs.
    add_pair(32767, 32767, 1'b1);
    add_pair(-32768, -32768, 1'b1);
    add_pair(-32768, 32767, 1'b1);
    add_pair(0, 0, 1'b1);
    add_pair(0, 12345, 1'b1);
    add_pair(1, 1, 1'b1);
    add_pair(1000, 0, 1'b0);
    add_pair(0, 1000, 1'b1);
    add_pair(5000, -5000, 1'b0);
    add_pair(-7000, 7000, 1'b1);
    // Integer roots push this ratio above one, so it must saturate.
    add_pair(3, 3, 1'b0);
    add_pair(3, 3, 1'b1);
    add_pair(-3, 3, 1'b0);
    add_pair(-3, 3, 1'b1);
    add_pair(32767, -32768, 1'b0);
    add_pair(-32768, 32767, 1'b1);
    // The highest threshold makes small vectors degenerate; full-scale elements still exceed it.
    add_marker(ITEM_CFG, 30'h3FFF_FFFF);
    add_pair(-32768, -32768, 1'b0);
    add_pair(-32768, -32768, 1'b1);
    add_pair(100, 200, 1'b1);
    add_marker(ITEM_CFG, 30'd0);
    // Vectors past the maximum length: the sums saturate silently.
    for (int i = 0; i < MaxLen + 10; i++) add_pair(-32768, -32768, i == MaxLen + 9);
    for (int i = 0; i < MaxLen + 5; i++) add_pair(-32768, 32767, i == MaxLen + 4);
    for (int i = 0; i < 20; i++) add_random_vector(40, 32768);
    add_marker(ITEM_PAUSE, '0);
    add_marker(ITEM_CFG, 30'($urandom_range(100, 4000)));
    for (int i = 0; i < 40; i++) add_random_vector(6, 64);
    add_marker(ITEM_CFG, 30'($urandom_range(1 << 20, 1 << 29)));
    for (int i = 0; i < 10; i++) add_random_vector(30, 32768);
    add_marker(ITEM_CFG, 30'd0);
    for (int i = 0; i < 10; i++) add_random_vector(30, 32768);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_q.size() == 0 && !push && expected_sims.size() == 0)) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && expected_sims.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end
endmodule
